// File: src/swlru_pkg.sv
// ----------------------------------------------------------------------------
// swlru_pkg
// shared constants and types of the size-weighted lru evictor
// ----------------------------------------------------------------------------
`default_nettype none
package swlru_pkg;

  localparam int ENTRIES = 32;
  localparam int IDW     = 5;
  localparam int CNTW    = $clog2(ENTRIES + 1);
  localparam int SZW     = 32;
  localparam int TOTW    = 37;
  localparam int FUNCW   = 3;
  localparam int IN_DW   = 40;
  localparam int OUT_DW  = 80;

  localparam logic [FUNCW-1:0] FUNC_ACCESS  = 3'd0;
  localparam logic [FUNCW-1:0] FUNC_RELEASE = 3'd1;
  localparam logic [FUNCW-1:0] FUNC_CLEAR   = 3'd2;
  localparam logic [FUNCW-1:0] FUNC_TRIM    = 3'd3;
  localparam logic [FUNCW-1:0] FUNC_HOLD    = 3'd4;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_RESERVE  = 1'b1;

  localparam logic [TOTW-1:0] RESERVE_RESET = 37'd1048576;

  typedef struct packed {
    logic [TOTW-1:0] used_total;
    logic            rejected;
    logic            threshold_met;
    logic            flush_ran;
    logic [SZW-1:0]  evicted_size;
    logic [IDW-1:0]  evicted_id;
  } res_t;

endpackage
`default_nettype wire

// File: src/swlru_ram.sv
// ----------------------------------------------------------------------------
// swlru_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module swlru_ram #(
  parameter int W  = 8,
  parameter int D  = 32,
  parameter int AW = $clog2(D)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: src/size_weighted_lru_evictor_top.sv
// ----------------------------------------------------------------------------
// size_weighted_lru_evictor_top
// lru list of sized cache entries with overflow, clear and trim eviction
// ----------------------------------------------------------------------------
// The recency list and the entry sizes live in two synchronous rams. One
// operation is taken at a time. Hold, reject and no-op go straight to the
// status step, and a plain add passes through the finish step first. Access to
// a resident entry, release, overflow eviction, clear and trim run one
// compaction pass over the recency list: each entry takes the list read, and
// each evicted entry then the size read, which waits out any stall on the
// result side. Release first reads the entry's size, before the pass.
// Every operation ends with one status transaction (tlast high, tuser 1),
// preceded by one eviction transaction (tuser 0) per evicted entry.
`default_nettype none
module size_weighted_lru_evictor_top
  import swlru_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [TOTW-1:0]   cfg_data_i,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // entry_id[4:0], entry_size[36:5], cacheable[37], held[38], zero[39]
  input  wire logic [IN_DW-1:0]  s_axis_tdata_i,
  // func[2:0]
  input  wire logic [FUNCW-1:0]  s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  // evicted_id[4:0], evicted_size[36:5], flush_ran[37], threshold_met[38],
  // rejected[39], used_total[76:40], zero[79:77]
  output logic [OUT_DW-1:0]      m_axis_tdata_o,
  // kind[0]
  output logic                   m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_REL, ST_RD, ST_ID, ST_SZ, ST_FIN, ST_STAT
  } state_e;

  state_e          state_q;
  logic [TOTW-1:0] cap_q, res_q, used_q, tgt_q, need_q;
  logic [TOTW:0]   freed_q;
  logic [CNTW-1:0] cnt_q, r_q, w_q;
  logic [ENTRIES-1:0] present_q, held_q;
  logic [IDW-1:0]  id_q, e_q;
  logic [SZW-1:0]  size_q;
  logic            shrink_q, reins_q, app_q, fr_q, tm_q, rej_q;
  logic            out_v_q, out_kind_q, out_last_q;
  logic            out_v_d;
  res_t            out_q;

  logic [IDW-1:0]  in_id;
  logic [SZW-1:0]  in_size;
  logic            in_cache, in_held, id_ok;
  logic [TOTW-1:0] tgt, sum;
  logic            can_emit;
  logic            op_clr, op_trm, op_acc, op_res, op_new, op_rej, op_add, op_ovf;
  logic            op_rel, op_hld;

  logic            ord_we, ord_re, sz_we, sz_re;
  logic [IDW-1:0]  ord_wa, ord_ra, sz_wa, sz_ra;
  logic [IDW-1:0]  ord_wd, ord_rd;
  logic [SZW-1:0]  sz_wd, sz_rd;

  assign in_id    = s_axis_tdata_i[4:0];
  assign in_size  = s_axis_tdata_i[36:5];
  assign in_cache = s_axis_tdata_i[37];
  assign in_held  = s_axis_tdata_i[38];
  assign id_ok    = CNTW'(in_id) < CNTW'(ENTRIES);
  assign tgt      = (cap_q > res_q) ? cap_q - res_q : '0;
  assign sum      = used_q + TOTW'(in_size);
  assign can_emit = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  // decode of the offered operation
  assign op_clr = (s_axis_tuser_i == FUNC_CLEAR) && (used_q != '0);
  assign op_trm = (s_axis_tuser_i == FUNC_TRIM) && (used_q > cap_q);
  assign op_acc = id_ok && (s_axis_tuser_i == FUNC_ACCESS);
  assign op_res = op_acc && present_q[in_id];
  assign op_new = op_acc && !present_q[in_id] && in_cache;
  assign op_rej = op_new && (TOTW'(in_size) > cap_q);
  assign op_add = op_new && !op_rej;
  assign op_ovf = op_add && (sum > cap_q);
  assign op_rel = id_ok && (s_axis_tuser_i == FUNC_RELEASE) && present_q[in_id];
  assign op_hld = id_ok && (s_axis_tuser_i == FUNC_HOLD);

  assign out_v_d = (can_emit && ((state_q == ST_SZ) || (state_q == ST_STAT))) ||
                   (out_v_q && !m_axis_tready_i);

  swlru_ram #(.W(IDW), .D(ENTRIES)) u_order (
    .clk_i, .we_i(ord_we), .waddr_i(ord_wa), .wdata_i(ord_wd),
    .re_i(ord_re), .raddr_i(ord_ra), .rdata_o(ord_rd)
  );

  swlru_ram #(.W(SZW), .D(ENTRIES)) u_size (
    .clk_i, .we_i(sz_we), .waddr_i(sz_wa), .wdata_i(sz_wd),
    .re_i(sz_re), .raddr_i(sz_ra), .rdata_o(sz_rd)
  );

  always_comb begin
    ord_we = 1'b0;
    ord_wa = w_q[IDW-1:0];
    ord_wd = ord_rd;
    ord_re = 1'b0;
    ord_ra = r_q[IDW-1:0];
    sz_we  = 1'b0;
    sz_wa  = id_q;
    sz_wd  = size_q;
    sz_re  = 1'b0;
    sz_ra  = in_id;
    case (state_q)
      ST_IDLE: begin
        sz_re = s_axis_tvalid_i;
      end
      ST_RD: begin
        ord_re = (r_q != cnt_q);
      end
      ST_ID: begin
        if (shrink_q) begin
          if (held_q[ord_rd] || (freed_q >= {1'b0, need_q})) begin
            ord_we = 1'b1;
          end else begin
            sz_re = 1'b1;
            sz_ra = ord_rd;
          end
        end else begin
          ord_we = (ord_rd != id_q);
        end
      end
      ST_FIN: begin
        ord_wd = id_q;
        if (reins_q) begin
          ord_we = (w_q != cnt_q);
        end else if (app_q && (w_q < CNTW'(ENTRIES))) begin
          ord_we = 1'b1;
          sz_we  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cap_q     <= '0;
      res_q     <= RESERVE_RESET;
      used_q    <= '0;
      cnt_q     <= '0;
      present_q <= '0;
      held_q    <= '0;
      out_v_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_CAPACITY) begin
          cap_q <= cfg_data_i;
        end else if (cfg_data_i != '0) begin
          res_q <= cfg_data_i;
        end
      end
      out_v_q <= out_v_d;
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            id_q     <= in_id;
            size_q   <= in_size;
            tgt_q    <= tgt;
            shrink_q <= op_clr || op_trm || op_ovf;
            reins_q  <= op_res;
            app_q    <= op_add;
            fr_q     <= op_ovf;
            tm_q     <= 1'b0;
            rej_q    <= op_rej;
            r_q      <= '0;
            w_q      <= (op_add && !op_ovf) ? cnt_q : '0;
            freed_q  <= '0;
            need_q   <= op_clr ? used_q : (op_trm ? used_q - cap_q : sum - tgt);
            if (op_add) begin
              used_q <= sum;
            end
            if (op_rel) begin
              present_q[in_id] <= 1'b0;
            end
            if (op_hld) begin
              held_q[in_id] <= in_held;
            end
            if (op_clr || op_trm || op_ovf || op_res) begin
              state_q <= ST_RD;
            end else if (op_rel) begin
              state_q <= ST_REL;
            end else if (op_add) begin
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_STAT;
            end
          end
        end
        ST_REL: begin
          used_q  <= used_q - TOTW'(sz_rd);
          state_q <= ST_RD;
        end
        ST_RD: begin
          state_q <= (r_q == cnt_q) ? ST_FIN : ST_ID;
        end
        ST_ID: begin
          e_q <= ord_rd;
          if (ord_we) begin
            w_q     <= w_q + 1'b1;
            r_q     <= r_q + 1'b1;
            state_q <= ST_RD;
          end else if (sz_re) begin
            state_q <= ST_SZ;
          end else begin
            r_q     <= r_q + 1'b1;
            state_q <= ST_RD;
          end
        end
        ST_SZ: begin
          if (can_emit) begin
            present_q[e_q] <= 1'b0;
            used_q   <= used_q - TOTW'(sz_rd);
            freed_q  <= freed_q + (TOTW+1)'(sz_rd);
            r_q      <= r_q + 1'b1;
            out_kind_q <= 1'b0;
            out_last_q <= 1'b0;
            out_q    <= '{used_total: used_q - TOTW'(sz_rd), rejected: 1'b0,
                          threshold_met: 1'b0, flush_ran: 1'b0,
                          evicted_size: sz_rd, evicted_id: e_q};
            state_q  <= ST_RD;
          end
        end
        ST_FIN: begin
          tm_q  <= fr_q && (used_q <= tgt_q);
          if (reins_q) begin
            cnt_q <= (w_q != cnt_q) ? w_q + 1'b1 : w_q;
          end else if (app_q && (w_q < CNTW'(ENTRIES))) begin
            cnt_q <= w_q + 1'b1;
            present_q[id_q] <= 1'b1;
          end else begin
            cnt_q <= w_q;
          end
          state_q <= ST_STAT;
        end
        ST_STAT: begin
          if (can_emit) begin
            out_kind_q <= 1'b1;
            out_last_q <= 1'b1;
            out_q      <= '{used_total: used_q, rejected: rej_q,
                            threshold_met: tm_q, flush_ran: fr_q,
                            evicted_size: '0, evicted_id: '0};
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {3'b000, out_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
`default_nettype wire
